// ----- src/bitmap_index_allocator_unit_macros.svh -----
// Assertion macros for the bitmap index allocator.
// Included by modules that carry concurrent assertions; expects clk and rst_n in scope.
`ifndef BITMAP_INDEX_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_INDEX_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BIA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BIA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/bia_pkg.sv -----
// Shared types and constants for the bitmap index allocator.
// No dependencies; imported by bitmap_index_allocator_unit.
package bia_pkg;

  localparam int BYTE_BITS = 8;
  localparam int ROW_BYTES = 8;
  localparam int ROW_W     = ROW_BYTES * BYTE_BITS;
  localparam int IDX_W     = 17;
  localparam int BASE_W    = 16;
  localparam int BYTES_W   = 10;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;

  localparam logic [BYTE_BITS-1:0] FULL_BYTE = 8'hFF;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_BAD_FREE = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic {
    REG_BASE_INDEX,
    REG_BYTES_IN_USE
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FREE_CHK,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic             opcode;
    logic [IDX_W-1:0] free_index;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0] granted_index;
    logic [1:0]       status;
  } out_t;

endpackage

// ----- src/bitmap_index_allocator_unit.sv -----
// Bitmap index allocator top level: free map memory, scan/free sequencer, APB registers.
// Depends on bia_pkg and bitmap_index_allocator_unit_macros.svh.
//
// First-fit bitmap allocator. The free map is held in one synchronous memory of
// ceil(MAP_BYTES/8) rows, 64 bits (eight map bytes) per row, with a registered read.
// An allocate transaction streams rows from row 0, one row per cycle, and stops at
// the first row that holds an active byte that is not all ones; it sets the lowest
// clear bit of that byte, writes the row back and answers base_index plus the bit
// position. The length of an allocate is set by the row scan through the memory read
// port, up to ceil(bytes_in_use/8) rows with bytes_in_use clamped to MAP_BYTES; a
// free transaction reads one row. A request refused at decode (an allocate with
// zero bytes in use, a free below base or beyond bytes in use) skips the memory.
// A result that waits on the output register holds the next transaction in its
// response state. One transaction is in work at a time, but a new one is taken
// while the previous result still waits on the output register. The map clears at
// reset without a clearing pass: a row fill mark tracks how many rows were ever
// written, and rows at or above it read as all free, which is exact because
// first-fit never writes past the first untouched row. Status reports map full and
// bad free (below base, beyond bytes in use, or a clear bit).
// Registers: 0x0 base_index[15:0], 0x4 bytes_in_use[9:0] (above MAP_BYTES acts as
// MAP_BYTES); write them only while idle.
module bitmap_index_allocator_unit #(
  parameter int MAP_BYTES = 512
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // request channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  bia_pkg::in_t               in_data,
  // result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output bia_pkg::out_t              out_data,
  // configuration port
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [bia_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [bia_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [bia_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import bia_pkg::*;

  localparam int ROWS   = (MAP_BYTES + ROW_BYTES - 1) / ROW_BYTES;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int HWM_W  = $clog2(ROWS + 1);
  localparam int LIM_W  = $clog2(MAP_BYTES + 1) + 3;

  // ---------------------------------------------------------------- registers
  state_t               state_r, state_nxt;
  logic [BASE_W-1:0]    cfg_base_r, cfg_base_nxt;
  logic [BYTES_W-1:0]   cfg_bytes_r, cfg_bytes_nxt;
  logic [HWM_W-1:0]     hwm_r, hwm_nxt;          // rows ever written
  logic [HWM_W-1:0]     scan_ptr_r, scan_ptr_nxt; // next row to read
  logic                 rd_vld_r, rd_vld_nxt;     // mem_q_r holds a row of this transaction
  logic [ROW_AW-1:0]    rd_row_r, rd_row_nxt;
  logic [ROW_AW-1:0]    last_row_r, last_row_nxt;
  logic [ROW_BYTES-1:0] last_mask_r, last_mask_nxt;
  logic [2:0]           fr_byte_r, fr_byte_nxt;
  logic [2:0]           fr_bit_r, fr_bit_nxt;
  out_t                 res_r, res_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_t                 out_data_r, out_data_nxt;

  // ---------------------------------------------------------------- memory
  logic [ROW_W-1:0]  mem [ROWS];
  logic [ROW_W-1:0]  mem_q_r;
  logic              mem_re, mem_we;
  logic [ROW_AW-1:0] mem_raddr, mem_waddr;
  logic [ROW_W-1:0]  mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_raddr];
    end
  end

  // ---------------------------------------------------------------- config port
  logic     cfg_wr;
  reg_idx_t cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[2]);

  always_comb begin
    cfg_base_nxt  = cfg_base_r;
    cfg_bytes_nxt = cfg_bytes_r;
    unique case (cfg_idx)
      REG_BASE_INDEX: begin
        cfg_prdata = {{(CFG_DW-BASE_W){1'b0}}, cfg_base_r};
        if (cfg_wr) cfg_base_nxt = cfg_pwdata[BASE_W-1:0];
      end
      REG_BYTES_IN_USE: begin
        cfg_prdata = {{(CFG_DW-BYTES_W){1'b0}}, cfg_bytes_r};
        if (cfg_wr) cfg_bytes_nxt = cfg_pwdata[BYTES_W-1:0];
      end
      default: begin
        cfg_prdata = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------- request decode
  logic             in_acc;
  logic [LIM_W-1:0] lim;        // bytes in use, clamped to the map
  logic [LIM_W-1:0] lim_dec;
  logic [IDX_W:0]   fr_diff;    // free_index - base, top bit is the borrow
  logic [IDX_W-1:0] fr_pos;
  logic             fr_ok;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  assign lim     = (32'(cfg_bytes_r) > MAP_BYTES) ? LIM_W'(MAP_BYTES) : LIM_W'(cfg_bytes_r);
  assign lim_dec = lim - LIM_W'(1);
  assign fr_diff = {1'b0, in_data.free_index} - {{(IDX_W+1-BASE_W){1'b0}}, cfg_base_r};
  assign fr_pos  = fr_diff[IDX_W-1:0];
  assign fr_ok   = !fr_diff[IDX_W] && (32'(fr_pos[IDX_W-1:3]) < 32'(lim));

  // ---------------------------------------------------------------- row evaluation
  logic [ROW_W-1:0]     row_data;   // rows at or above the fill mark are all free
  logic [ROW_BYTES-1:0] byte_mask;
  logic [ROW_BYTES-1:0] not_full;
  logic                 hit;
  logic [2:0]           hit_byte;
  logic [2:0]           hit_bit;
  logic [BYTE_BITS-1:0] hit_bits;
  logic [IDX_W-1:0]     grant_idx;
  logic [5:0]           fr_sel;
  logic                 fr_set;
  logic                 scan_last;
  logic                 scan_more;
  logic                 row_new;

  assign row_data  = ({1'b0, rd_row_r} < (ROW_AW+1)'(hwm_r)) ? mem_q_r : '0;
  assign byte_mask = (rd_row_r == last_row_r) ? last_mask_r : {ROW_BYTES{1'b1}};
  assign scan_last = (rd_row_r == last_row_r);
  assign scan_more = (32'(scan_ptr_r) <= 32'(last_row_r));
  assign row_new   = ({1'b0, rd_row_r} == (ROW_AW+1)'(hwm_r));

  always_comb begin
    for (int j = 0; j < ROW_BYTES; j++) begin
      not_full[j] = byte_mask[j] && (row_data[j*BYTE_BITS +: BYTE_BITS] != FULL_BYTE);
    end
  end

  assign hit = |not_full;

  // Pick the lowest byte with room, then its lowest clear bit.
  always_comb begin
    hit_byte = 3'd0;
    for (int j = ROW_BYTES - 1; j >= 0; j--) begin
      if (not_full[j]) hit_byte = 3'(j);
    end
  end

  assign hit_bits = row_data[hit_byte*BYTE_BITS +: BYTE_BITS];

  always_comb begin
    hit_bit = 3'd0;
    for (int b = BYTE_BITS - 1; b >= 0; b--) begin
      if (!hit_bits[b]) hit_bit = 3'(b);
    end
  end

  assign grant_idx = {{(IDX_W-BASE_W){1'b0}}, cfg_base_r} + IDX_W'({rd_row_r, hit_byte, hit_bit});
  assign fr_sel    = {fr_byte_r, fr_bit_r};
  assign fr_set    = row_data[fr_sel];

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data.opcode == OP_ALLOC) begin
            state_nxt = (lim == '0) ? ST_RESP : ST_SCAN;
          end else begin
            state_nxt = fr_ok ? ST_FREE_CHK : ST_RESP;
          end
        end
      end
      ST_SCAN: begin
        if (rd_vld_r && (hit || scan_last)) state_nxt = ST_RESP;
      end
      ST_FREE_CHK: begin
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------- datapath and outputs
  always_comb begin
    hwm_nxt       = hwm_r;
    scan_ptr_nxt  = scan_ptr_r;
    rd_vld_nxt    = 1'b0;
    rd_row_nxt    = rd_row_r;
    last_row_nxt  = last_row_r;
    last_mask_nxt = last_mask_r;
    fr_byte_nxt   = fr_byte_r;
    fr_bit_nxt    = fr_bit_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mem_re        = 1'b0;
    mem_raddr     = '0;
    mem_we        = 1'b0;
    mem_waddr     = rd_row_r;
    mem_wdata     = row_data;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          // Latch the scan window; it holds for the whole transaction.
          last_row_nxt  = ROW_AW'(lim_dec >> 3);
          last_mask_nxt = (lim[2:0] == 3'd0) ? {ROW_BYTES{1'b1}}
                                             : ROW_BYTES'((9'd1 << lim[2:0]) - 9'd1);
          fr_byte_nxt   = fr_pos[5:3];
          fr_bit_nxt    = fr_pos[2:0];
          res_nxt.granted_index = '0;
          if (in_data.opcode == OP_ALLOC) begin
            res_nxt.status = STAT_FULL;
            if (lim != '0) begin
              // Read row 0 now, continue from row 1.
              mem_re       = 1'b1;
              mem_raddr    = '0;
              rd_vld_nxt   = 1'b1;
              rd_row_nxt   = '0;
              scan_ptr_nxt = HWM_W'(1);
            end
          end else begin
            res_nxt.status = STAT_BAD_FREE;
            if (fr_ok) begin
              mem_re     = 1'b1;
              mem_raddr  = fr_pos[ROW_AW+5:6];
              rd_vld_nxt = 1'b1;
              rd_row_nxt = fr_pos[ROW_AW+5:6];
            end
          end
        end
      end
      ST_SCAN: begin
        if (rd_vld_r && hit) begin
          // Claim the bit and write the row back; advance the fill mark on a fresh row.
          mem_we    = 1'b1;
          mem_wdata = row_data | (ROW_W'(1) << {hit_byte, hit_bit});
          if (row_new) hwm_nxt = hwm_r + HWM_W'(1);
          res_nxt.granted_index = grant_idx;
          res_nxt.status        = STAT_OK;
        end else if (rd_vld_r && scan_last) begin
          res_nxt.status = STAT_FULL;
        end else begin
          // Keep the read stream going, one row per cycle.
          rd_vld_nxt = rd_vld_r || scan_more;
          if (scan_more) begin
            mem_re       = 1'b1;
            mem_raddr    = scan_ptr_r[ROW_AW-1:0];
            rd_row_nxt   = scan_ptr_r[ROW_AW-1:0];
            scan_ptr_nxt = scan_ptr_r + HWM_W'(1);
          end
        end
      end
      ST_FREE_CHK: begin
        if (fr_set) begin
          mem_we         = 1'b1;
          mem_wdata      = row_data & ~(ROW_W'(1) << fr_sel);
          res_nxt.status = STAT_OK;
        end else begin
          res_nxt.status = STAT_BAD_FREE;
        end
      end
      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------- flops
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_base_r  <= '0;
      cfg_bytes_r <= BYTES_W'(512);
      hwm_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cfg_base_r  <= cfg_base_nxt;
      cfg_bytes_r <= cfg_bytes_nxt;
      hwm_r       <= hwm_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_ptr_r  <= scan_ptr_nxt;
    rd_row_r    <= rd_row_nxt;
    last_row_r  <= last_row_nxt;
    last_mask_r <= last_mask_nxt;
    fr_byte_r   <= fr_byte_nxt;
    fr_bit_r    <= fr_bit_nxt;
    res_r       <= res_nxt;
    out_data_r  <= out_data_nxt;
  end

  // ---------------------------------------------------------------- assertions
`include "bitmap_index_allocator_unit_macros.svh"

  `BIA_ASSERT_IMPL(a_hwm_bound, 1'b1, 32'(hwm_r) <= ROWS, "fill mark beyond map rows")
  `BIA_ASSERT_IMPL(a_we_state, mem_we, (state_r == ST_SCAN) || (state_r == ST_FREE_CHK), "map write outside scan or free check")
  `BIA_ASSERT_IMPL(a_we_below_mark, mem_we, {1'b0, rd_row_r} <= (ROW_AW+1)'(hwm_r), "map write past first untouched row")
  `BIA_ASSERT_IMPL(a_zero_grant, out_valid_r && (out_data_r.status != STAT_OK), out_data_r.granted_index == '0, "nonzero index with error status")
  `BIA_ASSERT_NEXT(a_accept_busy, in_acc, state_r != ST_IDLE, "sequencer idle after accepting a transaction")

endmodule

// ----- bench/bitmap_index_allocator_unit_tb.sv -----
// Self-checking bench for bitmap_index_allocator_unit: directed table, then random phases.
// Depends on bia_pkg and the RTL top. Keeps its own copy of the free map to predict
// every grant and status.
module bitmap_index_allocator_unit_tb;
  import bia_pkg::*;

  localparam int MAP_BYTES      = 512;
  localparam int REG_STRIDE     = 4;
  localparam int RANDOM_ITEMS   = 800;
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off, fills the block
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 80;    // longer than the slowest scan
  localparam int WATCHDOG_LIMIT = 4000;  // cycles without any transaction
  localparam int PLAN_ROWS      = 28;

  typedef enum logic {
    ROW_REQ,
    ROW_CFG
  } row_kind_t;

  // One line of the directed table: a request, or a register write.
  // Where known is set, the outcome below is the one to see on the result channel.
  typedef struct packed {
    row_kind_t        kind;
    reg_idx_t         target;
    logic             op;
    logic [IDX_W-1:0] arg;
    logic             known;
    logic [IDX_W-1:0] grant;
    logic [1:0]       stat;
  } plan_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  in_t                in_data;
  logic               out_valid;
  logic               out_ready;
  out_t               out_data;
  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [CFG_AW-1:0]  cfg_paddr;
  logic [CFG_DW-1:0]  cfg_pwdata;
  logic [CFG_DW-1:0]  cfg_prdata;
  logic               cfg_pready;

  // Shadow copy of the block's state and registers.
  logic [BYTE_BITS-1:0] shadow_map [MAP_BYTES];
  int unsigned          shadow_base;
  int unsigned          shadow_bytes;

  // Outcomes owed by the block, oldest first.
  out_t grant_backlog [$];

  // Typed outcome for the request on the input channel, when the table gives one.
  logic typed_known;
  out_t typed_result;

  logic hold_request;
  logic burst_mode;

  int unsigned errors;
  int unsigned quiet_cycles;
  int unsigned n_alloc_req;
  int unsigned n_free_req;
  int unsigned n_ok;
  int unsigned n_full;
  int unsigned n_bad;
  int unsigned n_settings;

  // Directed table. Starts from reset: base 0, 512 bytes in use, map empty.
  plan_row_t directed_plan [PLAN_ROWS] = '{
    '{ROW_REQ, REG_BASE_INDEX,   OP_ALLOC, 17'd0,      1'b1, 17'd0,     STAT_OK},
    '{ROW_REQ, REG_BASE_INDEX,   OP_ALLOC, 17'd0,      1'b1, 17'd1,     STAT_OK},
    '{ROW_REQ, REG_BASE_INDEX,   OP_FREE,  17'd1,      1'b1, 17'd0,     STAT_OK},
    // freeing the same index twice hits a clear bit
    '{ROW_REQ, REG_BASE_INDEX,   OP_FREE,  17'd1,      1'b1, 17'd0,     STAT_BAD_FREE},
    '{ROW_REQ, REG_BASE_INDEX,   OP_FREE,  17'h1FFFF,  1'b1, 17'd0,     STAT_BAD_FREE},
    '{ROW_REQ, REG_BASE_INDEX,   OP_FREE,  17'd4095,   1'b1, 17'd0,     STAT_BAD_FREE},
    // free_index is ignored on allocate
    '{ROW_REQ, REG_BASE_INDEX,   OP_ALLOC, 17'h1FFFF,  1'b1, 17'd1,     STAT_OK},
    // one byte in use: fill it, then the map is exhausted
    '{ROW_CFG, REG_BYTES_IN_USE, OP_ALLOC, 17'd1,      1'b0, 17'd0,     STAT_OK},
    '{ROW_REQ, REG_BASE_INDEX,   OP_ALLOC, 17'd0,      1'b0, 17'd0,     STAT_OK},
    '{ROW_REQ, REG_BASE_INDEX,   OP_ALLOC, 17'd0,      1'b0, 17'd0,     STAT_OK},
    '{ROW_REQ, REG_BASE_INDEX,   OP_ALLOC, 17'd0,      1'b0, 17'd0,     STAT_OK},
    '{ROW_REQ, REG_BASE_INDEX,   OP_ALLOC, 17'd0,      1'b0, 17'd0,     STAT_OK},
    '{ROW_REQ, REG_BASE_INDEX,   OP_ALLOC, 17'd0,      1'b0, 17'd0,     STAT_OK},
    '{ROW_REQ, REG_BASE_INDEX,   OP_ALLOC, 17'd0,      1'b0, 17'd0,     STAT_OK},
    '{ROW_REQ, REG_BASE_INDEX,   OP_ALLOC, 17'd0,      1'b1, 17'd0,     STAT_FULL},
    // position 8 lies beyond the single byte in use
    '{ROW_REQ, REG_BASE_INDEX,   OP_FREE,  17'd8,      1'b1, 17'd0,     STAT_BAD_FREE},
    // largest base: free below it, free and reallocate above it
    '{ROW_CFG, REG_BASE_INDEX,   OP_ALLOC, 17'd65535,  1'b0, 17'd0,     STAT_OK},
    '{ROW_REQ, REG_BASE_INDEX,   OP_FREE,  17'd65534,  1'b1, 17'd0,     STAT_BAD_FREE},
    '{ROW_REQ, REG_BASE_INDEX,   OP_FREE,  17'd65538,  1'b1, 17'd0,     STAT_OK},
    '{ROW_REQ, REG_BASE_INDEX,   OP_ALLOC, 17'd0,      1'b1, 17'd65538, STAT_OK},
    // nothing in use: every request is refused
    '{ROW_CFG, REG_BYTES_IN_USE, OP_ALLOC, 17'd0,      1'b0, 17'd0,     STAT_OK},
    '{ROW_REQ, REG_BASE_INDEX,   OP_ALLOC, 17'd0,      1'b1, 17'd0,     STAT_FULL},
    '{ROW_REQ, REG_BASE_INDEX,   OP_FREE,  17'd65535,  1'b1, 17'd0,     STAT_BAD_FREE},
    // bytes in use above the map acts as the whole map
    '{ROW_CFG, REG_BYTES_IN_USE, OP_ALLOC, 17'd1023,   1'b0, 17'd0,     STAT_OK},
    '{ROW_REQ, REG_BASE_INDEX,   OP_ALLOC, 17'd0,      1'b1, 17'd65543, STAT_OK},
    '{ROW_REQ, REG_BASE_INDEX,   OP_FREE,  17'h1FFFF,  1'b1, 17'd0,     STAT_BAD_FREE},
    '{ROW_CFG, REG_BASE_INDEX,   OP_ALLOC, 17'd0,      1'b0, 17'd0,     STAT_OK},
    '{ROW_REQ, REG_BASE_INDEX,   OP_FREE,  17'd8,      1'b1, 17'd0,     STAT_OK}
  };

  bitmap_index_allocator_unit #(
    .MAP_BYTES(MAP_BYTES)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Apply one request to the shadow map and return the outcome it must produce.
  // First fit: lowest clear bit of the first byte in use that is not all ones.
  function automatic out_t allocate_or_release(in_t req);
    out_t        res;
    int unsigned active;
    int unsigned pos;
    int unsigned k;
    int unsigned b;
    bit          done;
    res    = '0;
    active = (shadow_bytes > MAP_BYTES) ? MAP_BYTES : shadow_bytes;
    if (req.opcode == OP_ALLOC) begin
      res.status = STAT_FULL;
      done = 1'b0;
      for (k = 0; k < active && !done; k++) begin
        if (shadow_map[k] != FULL_BYTE) begin
          b = 0;
          while (shadow_map[k][b]) b++;
          shadow_map[k][b]  = 1'b1;
          res.granted_index = IDX_W'(shadow_base + k * BYTE_BITS + b);
          res.status        = STAT_OK;
          done              = 1'b1;
        end
      end
    end else if (req.free_index < shadow_base) begin
      res.status = STAT_BAD_FREE;
    end else begin
      pos = req.free_index - shadow_base;
      k   = pos / BYTE_BITS;
      b   = pos % BYTE_BITS;
      if (k >= active || !shadow_map[k][b]) begin
        res.status = STAT_BAD_FREE;
      end else begin
        shadow_map[k][b] = 1'b0;
        res.status       = STAT_OK;
      end
    end
    return res;
  endfunction

  // Draw a random request: mostly allocations and frees of taken positions, the rest
  // frees below the base, past the bytes in use, of any position in use, or of any index.
  function automatic in_t next_request();
    in_t         req;
    int unsigned active;
    int unsigned span;
    int unsigned start;
    int unsigned pos;
    int unsigned i;
    int unsigned r;
    bit          found;
    active         = (shadow_bytes > MAP_BYTES) ? MAP_BYTES : shadow_bytes;
    span           = active * BYTE_BITS;
    req.opcode     = OP_FREE;
    req.free_index = IDX_W'($urandom);
    r              = $urandom_range(0, 99);
    if (r < 50) begin
      req.opcode = OP_ALLOC;
    end else if (r < 85 && span > 0) begin
      // walk from a random spot to the next taken position, wrapping around
      start = $urandom_range(0, span - 1);
      found = 1'b0;
      pos   = 0;
      for (i = 0; i < span && !found; i++) begin
        pos = (start + i) % span;
        if (shadow_map[pos / BYTE_BITS][pos % BYTE_BITS]) found = 1'b1;
      end
      if (found) req.free_index = IDX_W'(shadow_base + pos);
    end else begin
      case ($urandom_range(0, 3))
        0: ;
        1: if (shadow_base > 0) req.free_index = IDX_W'($urandom_range(0, shadow_base - 1));
        2: req.free_index = IDX_W'(shadow_base + span + $urandom_range(0, 15));
        default: begin
          req.free_index = IDX_W'(shadow_base + $urandom_range(0, (span > 0) ? span - 1 : 0));
        end
      endcase
    end
    return req;
  endfunction

  // Offer one request after a random gap; return at the edge that accepts it.
  // Build the request only after the falling edge so the shadow map has taken
  // the previous transaction.
  task automatic offer(input bit planned, input plan_row_t row);
    int unsigned gap;
    int unsigned r;
    in_t         req;
    gap = 0;
    if (!burst_mode) begin
      r = $urandom_range(0, 99);
      if (r >= 92) gap = $urandom_range(8, 40);
      else if (r >= 65) gap = $urandom_range(1, 3);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    if (planned) begin
      req.opcode     = row.op;
      req.free_index = row.arg;
      typed_known    = row.known;
      typed_result   = '{granted_index: row.grant, status: row.stat};
    end else begin
      req         = next_request();
      typed_known = 1'b0;
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and hold the sender until every owed outcome has come back.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (grant_backlog.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle; only while the block is idle.
  task automatic write_reg(input reg_idx_t target, input int unsigned value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'(REG_STRIDE * int'(target));
    cfg_pwdata  <= CFG_DW'(value);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (target)
      REG_BASE_INDEX:   shadow_base  = value & 32'h0000_FFFF;
      REG_BYTES_IN_USE: shadow_bytes = value & 32'h0000_03FF;
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Receiver: ready most of the time, short and long stalls, and on request one
  // long hold-off so the block fills up and stalls its input.
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned r;
    out_ready  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!burst_mode) begin
          r = $urandom_range(0, 99);
          if (r < 8) stall_left = $urandom_range(1, 3);
          else if (r < 10) stall_left = $urandom_range(15, 50);
        end
      end
    end
  end

  // Monitor: predict at each accepted request, check each accepted result.
  always @(posedge clk) begin : scoreboard
    out_t predicted;
    out_t owed;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predicted = allocate_or_release(in_data);
        if (in_data.opcode == OP_ALLOC) n_alloc_req++;
        else n_free_req++;
        // the table's own outcome takes precedence where it gives one
        grant_backlog.push_back(typed_known ? typed_result : predicted);
      end
      if (out_valid && out_ready) begin
        if (grant_backlog.size() == 0) begin
          $display("%0t: result with nothing owed: index %0d status %0d",
                   $time, out_data.granted_index, out_data.status);
          errors++;
        end else begin
          owed = grant_backlog.pop_front();
          if (out_data.granted_index !== owed.granted_index) begin
            $display("%0t: granted_index mismatch: expected %0d, got %0d",
                     $time, owed.granted_index, out_data.granted_index);
            errors++;
          end
          if (out_data.status !== owed.status) begin
            $display("%0t: status mismatch: expected %0d, got %0d",
                     $time, owed.status, out_data.status);
            errors++;
          end
          case (owed.status)
            STAT_OK:   n_ok++;
            STAT_FULL: n_full++;
            default:   n_bad++;
          endcase
        end
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: timeout, no transaction for %0d cycles, %0d results owed",
               $time, WATCHDOG_LIMIT, grant_backlog.size());
      $display("bitmap_index_allocator_unit_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned row;
    int unsigned item;
    int unsigned phase;
    int unsigned phase_len;
    int unsigned random_sent;
    int unsigned r;
    int unsigned base_pick;
    int unsigned bytes_pick;
    // drive every input to a known value from time zero
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    typed_known  = 1'b0;
    typed_result = '0;
    hold_request = 1'b0;
    burst_mode   = 1'b0;
    errors       = 0;
    quiet_cycles = 0;
    n_alloc_req  = 0;
    n_free_req   = 0;
    n_ok         = 0;
    n_full       = 0;
    n_bad        = 0;
    n_settings   = 0;
    random_sent  = 0;
    shadow_base  = 0;
    shadow_bytes = MAP_BYTES;
    for (int i = 0; i < MAP_BYTES; i++) shadow_map[i] = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (row = 0; row < PLAN_ROWS; row++) begin
      if (directed_plan[row].kind == ROW_CFG) begin
        settle();
        write_reg(directed_plan[row].target, directed_plan[row].arg);
        n_settings++;
      end else begin
        offer(1'b1, directed_plan[row]);
      end
    end

    // random phases, each under a fresh setting; small maps dominate so the
    // map fills up and scans stay short, the whole map and beyond show up too
    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      settle();
      r = $urandom_range(0, 99);
      if (r < 15) base_pick = 0;
      else if (r < 30) base_pick = 65535;
      else base_pick = $urandom_range(0, 65535);
      r = $urandom_range(0, 99);
      if (r < 5) bytes_pick = 0;
      else if (r < 35) bytes_pick = $urandom_range(1, 4);
      else if (r < 65) bytes_pick = $urandom_range(5, 16);
      else if (r < 80) bytes_pick = $urandom_range(17, 64);
      else if (r < 88) bytes_pick = MAP_BYTES;
      else if (r < 95) bytes_pick = $urandom_range(MAP_BYTES + 1, 1023);
      else bytes_pick = $urandom_range(65, MAP_BYTES - 1);
      write_reg(REG_BASE_INDEX, base_pick);
      write_reg(REG_BYTES_IN_USE, bytes_pick);
      n_settings++;
      burst_mode = ($urandom_range(0, 3) == 0);
      phase_len  = $urandom_range(20, 60);
      // back-pressure: the receiver holds off while the sender keeps offering
      if (phase == 2 || phase == 9) begin
        hold_request = 1'b1;
        burst_mode   = 1'b1;
      end
      for (item = 0; item < phase_len; item++) begin
        // pause the sender mid-phase until the block has drained
        if (phase % 4 == 1 && item == phase_len / 2) settle();
        offer(1'b0, '0);
        random_sent++;
      end
      phase++;
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d requests (%0d allocate, %0d free) under %0d register settings.",
             n_alloc_req + n_free_req, n_alloc_req, n_free_req, n_settings);
    $display("Outcomes: %0d ok, %0d map full, %0d rejected free; %0d mismatches.",
             n_ok, n_full, n_bad, errors);
    if (errors == 0) begin
      $display("bitmap_index_allocator_unit_tb OK");
    end else begin
      $display("bitmap_index_allocator_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/bia_pkg.sv
src/bitmap_index_allocator_unit.sv
bench/bitmap_index_allocator_unit_tb.sv
